// ----- sv/lsc_pkg.sv -----
// Shared constants for the level-set curvature and upwind gradient block.
// Used by the top level and by its port checker; depends on nothing.
`timescale 1ns / 1ps

package lsc_pkg;

    // Result widths.
    localparam int CURV_W = 32;
    localparam int GRAD_W = 25;

    // Quotient bits produced by the curvature divider (one above the result).
    localparam int QUO_W = CURV_W + 1;

    // Saturation limits.
    localparam logic [GRAD_W-1:0] GRAD_MAX = '1;
    localparam logic [CURV_W-1:0] CURV_POS_MAX = {1'b0, {(CURV_W-1){1'b1}}};
    localparam logic [CURV_W-1:0] CURV_NEG_MIN = {1'b1, {(CURV_W-1){1'b0}}};

    // Configuration register indexes.
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // Configuration reset values.
    localparam int FRAME_WIDTH_RST  = 640;
    localparam int FRAME_HEIGHT_RST = 480;

endpackage

// ----- sv/level_set_curvature_upwind_top.sv -----
// Level-set curvature and upwind gradient magnitudes over a 3x3 window.
// Depends on lsc_pkg and lsc_isqrt.
//
// Channel  Direction  Handshake              Payload
// input    in         in_valid / in_ready    x_pos, y_pos, u_center .. u_down_right
// output   out        out_valid / out_ready  curvature, grad_minus, grad_plus
// config   in         cfg_we                 cfg_index, cfg_data
//
// One item enters per cycle while the output is not stalled; the pipeline holds
// SAMPLE_BITS + FRAC_BITS + 1 square root stages and 33 divider stages.
// The divider and square roots retire one bit per stage, which sets the depth.
// Reset clears the valid bits and restores the frame size registers.
// A stall at the output freezes the whole pipeline; nothing is dropped or repeated.
`timescale 1ns / 1ps

module level_set_curvature_upwind_top #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8,
    parameter int MAX_DIM     = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [$clog2(MAX_DIM)-1:0]          x_pos,
    input  logic [$clog2(MAX_DIM)-1:0]          y_pos,
    input  logic signed [SAMPLE_BITS-1:0]       u_center,
    input  logic signed [SAMPLE_BITS-1:0]       u_left,
    input  logic signed [SAMPLE_BITS-1:0]       u_right,
    input  logic signed [SAMPLE_BITS-1:0]       u_up,
    input  logic signed [SAMPLE_BITS-1:0]       u_down,
    input  logic signed [SAMPLE_BITS-1:0]       u_up_left,
    input  logic signed [SAMPLE_BITS-1:0]       u_up_right,
    input  logic signed [SAMPLE_BITS-1:0]       u_down_left,
    input  logic signed [SAMPLE_BITS-1:0]       u_down_right,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [lsc_pkg::CURV_W-1:0]   curvature,
    output logic [lsc_pkg::GRAD_W-1:0]          grad_minus,
    output logic [lsc_pkg::GRAD_W-1:0]          grad_plus,
    input  logic                                cfg_we,
    input  logic [lsc_pkg::REG_IDX_W-1:0]       cfg_index,
    input  logic [$clog2(MAX_DIM):0]            cfg_data
);

    localparam int S     = SAMPLE_BITS;
    localparam int F     = FRAC_BITS;
    localparam int POS_W = $clog2(MAX_DIM);
    localparam int DIM_W = POS_W + 1;
    localparam int D1_W  = S + 1;             // first differences
    localparam int D2_W  = S + 2;             // second and cross differences
    localparam int SQ_W  = 2 * S;             // squares of first differences
    localparam int YX_W  = 2 * D1_W;          // ux*uy product
    localparam int P1_W  = D2_W + SQ_W + 1;   // uxx*uy^2 and uyy*ux^2
    localparam int P2_W  = YX_W + D2_W;       // ux*uy*uxy
    localparam int NUM_W = 3 * S + 5;         // eight times the numerator
    localparam int MAG_W = 3 * S + 4;
    localparam int Q2_W  = 2 * S + 1;
    localparam int GS_W  = 2 * S + 2;         // upwind sums of squares
    localparam int RAD_W = GS_W + 2 * F;
    localparam int RT_W  = RAD_W / 2;
    localparam int QB    = lsc_pkg::QUO_W;
    localparam int DV_W  = 2 * S + 3;         // divisor 8*del^2
    localparam int HI_W  = MAG_W + F;
    localparam int NX_W  = HI_W + QB;
    localparam int CMP_W = (HI_W > DV_W ? HI_W : DV_W) + 1;
    localparam int GW    = lsc_pkg::GRAD_W;
    localparam int CW    = lsc_pkg::CURV_W;
    localparam int LAT   = RT_W + QB + 8;

    // Stage enable: the pipeline moves unless a finished item waits.
    logic [LAT-1:0] vld_reg;
    logic           en;

    assign en        = !vld_reg[LAT-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    // Frame size registers.
    logic [DIM_W-1:0] fw_reg;
    logic [DIM_W-1:0] fh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= DIM_W'(lsc_pkg::FRAME_WIDTH_RST);
            fh_reg <= DIM_W'(lsc_pkg::FRAME_HEIGHT_RST);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lsc_pkg::REG_FRAME_WIDTH:  fw_reg <= cfg_data;
                lsc_pkg::REG_FRAME_HEIGHT: fh_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 1: border detection and finite differences.
    logic xb;
    logic yb;

    assign xb = (x_pos == '0) || ((fw_reg != '0) && ({1'b0, x_pos} == fw_reg - DIM_W'(1)));
    assign yb = (y_pos == '0) || ((fh_reg != '0) && ({1'b0, y_pos} == fh_reg - DIM_W'(1)));

    logic signed [D1_W-1:0] x2_next, y2_next, xm_next, xp_next, ym_next, yp_next;
    logic signed [D2_W-1:0] xx_next, yy_next, xy_next;
    logic signed [D1_W-1:0] x2_reg, y2_reg, xm_reg, xp_reg, ym_reg, yp_reg;
    logic signed [D2_W-1:0] xx_reg, yy_reg, xy_reg;

    always_comb
    begin
        x2_next = '0;
        xm_next = '0;
        xp_next = '0;
        xx_next = '0;
        y2_next = '0;
        ym_next = '0;
        yp_next = '0;
        yy_next = '0;
        xy_next = '0;
        if (!xb)
        begin
            x2_next = D1_W'(u_right) - D1_W'(u_left);
            xm_next = D1_W'(u_center) - D1_W'(u_left);
            xp_next = D1_W'(u_right) - D1_W'(u_center);
            xx_next = D2_W'(u_right) - (D2_W'(u_center) <<< 1) + D2_W'(u_left);
        end
        if (!yb)
        begin
            y2_next = D1_W'(u_down) - D1_W'(u_up);
            ym_next = D1_W'(u_center) - D1_W'(u_up);
            yp_next = D1_W'(u_down) - D1_W'(u_center);
            yy_next = D2_W'(u_down) - (D2_W'(u_center) <<< 1) + D2_W'(u_up);
        end
        if (!xb && !yb)
        begin
            xy_next = D2_W'(u_down_right) - D2_W'(u_up_right)
                    - D2_W'(u_down_left) + D2_W'(u_up_left);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x2_reg <= x2_next;
            y2_reg <= y2_next;
            xm_reg <= xm_next;
            xp_reg <= xp_next;
            ym_reg <= ym_next;
            yp_reg <= yp_next;
            xx_reg <= xx_next;
            yy_reg <= yy_next;
            xy_reg <= xy_next;
        end
    end

    // Stage 2: squares of the first differences and the ux*uy product.
    logic signed [YX_W-1:0] x2sq_full, y2sq_full, yx_full;
    logic [S-1:0]           axm, axp, aym, ayp;
    logic signed [D1_W-1:0] nxm, nxp, nym, nyp;

    assign x2sq_full = x2_reg * x2_reg;
    assign y2sq_full = y2_reg * y2_reg;
    assign yx_full   = y2_reg * x2_reg;
    assign nxm = -xm_reg;
    assign nxp = -xp_reg;
    assign nym = -ym_reg;
    assign nyp = -yp_reg;
    assign axm = xm_reg[D1_W-1] ? nxm[S-1:0] : xm_reg[S-1:0];
    assign axp = xp_reg[D1_W-1] ? nxp[S-1:0] : xp_reg[S-1:0];
    assign aym = ym_reg[D1_W-1] ? nym[S-1:0] : ym_reg[S-1:0];
    assign ayp = yp_reg[D1_W-1] ? nyp[S-1:0] : yp_reg[S-1:0];

    logic [SQ_W-1:0]        x2sq_reg, y2sq_reg;
    logic signed [YX_W-1:0] yx_reg;
    logic signed [D2_W-1:0] xx2_reg, yy2_reg, xy2_reg;
    logic [SQ_W-1:0]        sxm_reg, sxp_reg, sym_reg, syp_reg;
    logic                   nxm_reg, nxp_reg, nym_reg, nyp_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x2sq_reg <= x2sq_full[SQ_W-1:0];
            y2sq_reg <= y2sq_full[SQ_W-1:0];
            yx_reg   <= yx_full;
            xx2_reg  <= xx_reg;
            yy2_reg  <= yy_reg;
            xy2_reg  <= xy_reg;
            sxm_reg  <= axm * axm;
            sxp_reg  <= axp * axp;
            sym_reg  <= aym * aym;
            syp_reg  <= ayp * ayp;
            nxm_reg  <= xm_reg[D1_W-1];
            nxp_reg  <= xp_reg[D1_W-1];
            nym_reg  <= ym_reg[D1_W-1];
            nyp_reg  <= yp_reg[D1_W-1];
        end
    end

    // Stage 3: numerator products, gradient sum and upwind sums.
    logic signed [P1_W-1:0] p1_reg, p3_reg;
    logic signed [P2_W-1:0] p2_reg;
    logic [Q2_W-1:0]        q2_sum;
    logic [Q2_W-3:0]        q2s_reg;
    logic [GS_W-1:0]        gm_sum, gp_sum;
    logic [GS_W-1:0]        gm_reg, gp_reg;

    assign q2_sum = Q2_W'(x2sq_reg) + Q2_W'(y2sq_reg);

    // A negative difference feeds the minus side for the plus-direction
    // differences and the plus side for the minus-direction ones.
    assign gm_sum = (nxm_reg ? '0 : GS_W'(sxm_reg)) + (nxp_reg ? GS_W'(sxp_reg) : '0)
                  + (nym_reg ? '0 : GS_W'(sym_reg)) + (nyp_reg ? GS_W'(syp_reg) : '0);
    assign gp_sum = (nxm_reg ? GS_W'(sxm_reg) : '0) + (nxp_reg ? '0 : GS_W'(sxp_reg))
                  + (nym_reg ? GS_W'(sym_reg) : '0) + (nyp_reg ? '0 : GS_W'(syp_reg));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg  <= xx2_reg * $signed({1'b0, y2sq_reg});
            p3_reg  <= yy2_reg * $signed({1'b0, x2sq_reg});
            p2_reg  <= yx_reg * xy2_reg;
            q2s_reg <= q2_sum[Q2_W-1:2];
            gm_reg  <= gm_sum;
            gp_reg  <= gp_sum;
        end
    end

    // Stage 4: eight times the numerator.
    logic signed [NUM_W-1:0] num_reg;
    logic [Q2_W-3:0]         q2s4_reg;
    logic [GS_W-1:0]         gm4_reg, gp4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg  <= (NUM_W'(p1_reg) <<< 1) - NUM_W'(p2_reg) + (NUM_W'(p3_reg) <<< 1);
            q2s4_reg <= q2s_reg;
            gm4_reg  <= gm_reg;
            gp4_reg  <= gp_reg;
        end
    end

    // Stage 5: sign and magnitude, square root radicands.
    logic signed [NUM_W-1:0] num_neg;
    logic                    neg5_reg;
    logic [MAG_W-1:0]        mag5_reg;
    logic [RAD_W-1:0]        rq_reg, rm_reg, rp_reg;

    assign num_neg = -num_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg5_reg <= num_reg[NUM_W-1];
            mag5_reg <= num_reg[NUM_W-1] ? num_neg[MAG_W-1:0] : num_reg[MAG_W-1:0];
            rq_reg   <= RAD_W'(q2s4_reg);
            rm_reg   <= RAD_W'(gm4_reg) << (2 * F);
            rp_reg   <= RAD_W'(gp4_reg) << (2 * F);
        end
    end

    // Square roots: del and both upwind magnitudes.
    logic [RT_W-1:0] del_root, gm_root, gp_root;

    lsc_isqrt #(.RAD_W(RAD_W)) u_sqrt_del (
        .clk  (clk),
        .en   (en),
        .rad  (rq_reg),
        .root (del_root)
    );

    lsc_isqrt #(.RAD_W(RAD_W)) u_sqrt_gm (
        .clk  (clk),
        .en   (en),
        .rad  (rm_reg),
        .root (gm_root)
    );

    lsc_isqrt #(.RAD_W(RAD_W)) u_sqrt_gp (
        .clk  (clk),
        .en   (en),
        .rad  (rp_reg),
        .root (gp_root)
    );

    // Sign and magnitude ride alongside the square root stages.
    logic [MAG_W-1:0] sd_mag_reg [RT_W];
    logic             sd_neg_reg [RT_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd_mag_reg[0] <= mag5_reg;
            sd_neg_reg[0] <= neg5_reg;
            for (int i = 1; i < RT_W; i++)
            begin
                sd_mag_reg[i] <= sd_mag_reg[i-1];
                sd_neg_reg[i] <= sd_neg_reg[i-1];
            end
        end
    end

    // Gradient saturation to the result width.
    logic [GW-1:0] gm_sat, gp_sat;

    generate
        if (RT_W > GW)
        begin : g_gsat
            assign gm_sat = (gm_root > RT_W'(lsc_pkg::GRAD_MAX)) ? lsc_pkg::GRAD_MAX
                                                                  : gm_root[GW-1:0];
            assign gp_sat = (gp_root > RT_W'(lsc_pkg::GRAD_MAX)) ? lsc_pkg::GRAD_MAX
                                                                  : gp_root[GW-1:0];
        end
        else
        begin : g_gext
            assign gm_sat = GW'(gm_root);
            assign gp_sat = GW'(gp_root);
        end
    endgenerate

    // Square of the truncated gradient magnitude.
    logic [SQ_W-1:0]  dsq_reg;
    logic [MAG_W-1:0] magm_reg;
    logic             negm_reg;
    logic [GW-1:0]    gmm_reg, gpm_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dsq_reg  <= del_root[S-1:0] * del_root[S-1:0];
            magm_reg <= sd_mag_reg[RT_W-1];
            negm_reg <= sd_neg_reg[RT_W-1];
            gmm_reg  <= gm_sat;
            gpm_reg  <= gp_sat;
        end
    end

    // Divider set-up: overflow check and first partial remainder.
    logic [DV_W-1:0] dvs;
    logic [NX_W-1:0] nx;
    logic [HI_W-1:0] nhi;

    assign dvs = {dsq_reg, 3'b000};
    assign nx  = NX_W'(magm_reg) << F;
    assign nhi = nx[NX_W-1:QB];

    logic [DV_W-1:0] drem_reg [QB];
    logic [DV_W-1:0] d_reg    [QB];
    logic [QB-1:0]   lo_reg   [QB];
    logic [QB-1:0]   q_reg    [QB+1];
    logic            neg_reg  [QB+1];
    logic            ov_reg   [QB+1];
    logic            zm_reg   [QB+1];
    logic            zd_reg   [QB+1];
    logic [GW-1:0]   gmd_reg  [QB+1];
    logic [GW-1:0]   gpd_reg  [QB+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            drem_reg[0] <= DV_W'(nhi);
            d_reg[0]    <= dvs;
            lo_reg[0]   <= nx[QB-1:0];
            q_reg[0]    <= '0;
            neg_reg[0]  <= negm_reg;
            ov_reg[0]   <= (CMP_W'(nhi) >= CMP_W'(dvs));
            zm_reg[0]   <= (magm_reg == '0);
            zd_reg[0]   <= (dsq_reg == '0);
            gmd_reg[0]  <= gmm_reg;
            gpd_reg[0]  <= gpm_reg;
        end
    end

    // Restoring division, one quotient bit per stage.
    genvar di;
    generate
        for (di = 0; di < QB; di++)
        begin : g_div
            logic [DV_W:0]   t;
            logic [DV_W:0]   diff;
            logic            ge;
            logic [DV_W-1:0] rem_nx;

            assign t      = {drem_reg[di], lo_reg[di][QB-1-di]};
            assign ge     = (t >= {1'b0, d_reg[di]});
            assign diff   = t - {1'b0, d_reg[di]};
            assign rem_nx = ge ? diff[DV_W-1:0] : t[DV_W-1:0];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    q_reg[di+1]   <= {q_reg[di][QB-2:0], ge};
                    neg_reg[di+1] <= neg_reg[di];
                    ov_reg[di+1]  <= ov_reg[di];
                    zm_reg[di+1]  <= zm_reg[di];
                    zd_reg[di+1]  <= zd_reg[di];
                    gmd_reg[di+1] <= gmd_reg[di];
                    gpd_reg[di+1] <= gpd_reg[di];
                end
            end

            if (di < QB - 1)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        drem_reg[di+1] <= rem_nx;
                        d_reg[di+1]    <= d_reg[di];
                        lo_reg[di+1]   <= lo_reg[di];
                    end
                end
            end
        end
    endgenerate

    // Output stage: zero and saturation handling.
    logic [QB-1:0] qf;
    logic [CW-1:0] qneg;
    logic [CW-1:0] curv_next;

    assign qf   = q_reg[QB];
    assign qneg = -qf[CW-1:0];

    always_comb
    begin
        if (zm_reg[QB])
        begin
            curv_next = '0;
        end
        else if (zd_reg[QB])
        begin
            curv_next = neg_reg[QB] ? lsc_pkg::CURV_NEG_MIN : lsc_pkg::CURV_POS_MAX;
        end
        else if (neg_reg[QB])
        begin
            curv_next = (ov_reg[QB] || (qf > QB'(lsc_pkg::CURV_NEG_MIN)))
                      ? lsc_pkg::CURV_NEG_MIN : qneg;
        end
        else
        begin
            curv_next = (ov_reg[QB] || (qf > QB'(lsc_pkg::CURV_POS_MAX)))
                      ? lsc_pkg::CURV_POS_MAX : qf[CW-1:0];
        end
    end

    logic [CW-1:0] curv_reg;
    logic [GW-1:0] gmo_reg, gpo_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            curv_reg <= curv_next;
            gmo_reg  <= gmd_reg[QB];
            gpo_reg  <= gpd_reg[QB];
        end
    end

    assign curvature  = curv_reg;
    assign grad_minus = gmo_reg;
    assign grad_plus  = gpo_reg;

endmodule

// ----- sv/lsc_isqrt.sv -----
// Pipelined integer square root, one result bit per register stage.
// Digit-by-digit restoring method; no package dependencies.
`timescale 1ns / 1ps

module lsc_isqrt #(
    parameter int RAD_W = 50
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [RAD_W-1:0]     rad,
    output logic [RAD_W/2-1:0]   root
);

    localparam int RT_W = RAD_W / 2;

    logic [RT_W-1:0]  root_reg [RT_W];
    logic [RT_W-1:0]  rem_reg  [RT_W-1];
    logic [RAD_W-1:0] rest_reg [RT_W-1];

    genvar k;
    generate
        for (k = 0; k < RT_W; k++)
        begin : g_stage
            logic [RT_W-1:0]  rem_in;
            logic [RT_W-1:0]  root_in;
            logic [RAD_W-1:0] rest_in;
            logic [RT_W+1:0]  t;
            logic [RT_W+1:0]  trial;
            logic [RT_W+1:0]  diff;
            logic             ge;
            logic [RT_W+1:0]  rem_full;

            // Stage inputs: the radicand enters the first stage.
            if (k == 0)
            begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign rest_in = rad;
            end
            else
            begin : g_next
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign rest_in = rest_reg[k-1];
            end

            // Bring down two radicand bits and try the next root bit.
            assign t        = {rem_in, rest_in[RAD_W-1 -: 2]};
            assign trial    = {root_in, 2'b01};
            assign ge       = (t >= trial);
            assign diff     = t - trial;
            assign rem_full = ge ? diff : t;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    root_reg[k] <= {root_in[RT_W-2:0], ge};
                end
            end

            // The last stage keeps only the root.
            if (k < RT_W - 1)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[k]  <= rem_full[RT_W-1:0];
                        rest_reg[k] <= rest_in << 2;
                    end
                end
            end
        end
    endgenerate

    assign root = root_reg[RT_W-1];

endmodule

// ----- sv/lsc_checker.sv -----
// Port-level checks for the level-set curvature block, bound to its top level.
// Depends on lsc_pkg for result widths.
`timescale 1ns / 1ps

module lsc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [lsc_pkg::CURV_W-1:0]  curvature,
    input logic [lsc_pkg::GRAD_W-1:0]  grad_minus,
    input logic [lsc_pkg::GRAD_W-1:0]  grad_plus
);

    // The input side is open whenever the output stage can move.
    a_ready_open: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("input stalled while the output stage could advance");

    // A waiting result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(curvature)
            && $stable(grad_minus) && $stable(grad_plus)))
        else $error("output item changed or vanished while stalled");

    // No result is shown while reset is held.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("output valid during reset");

endmodule

bind level_set_curvature_upwind_top lsc_checker u_lsc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .curvature  (curvature),
    .grad_minus (grad_minus),
    .grad_plus  (grad_plus)
);
